// File: design/scored_doc_topk_pager_defines.svh
// Assertion macros for the scored document top-k pager.
// Taken in by the top level; expects clk and rst in scope.
`ifndef SCORED_DOC_TOPK_PAGER_DEFINES_SVH
`define SCORED_DOC_TOPK_PAGER_DEFINES_SVH

// Same-cycle implication
`define SDTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SDTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sdtp_pkg.sv
// Shared constants, types and helpers for the scored document top-k pager.
// No dependencies.
`timescale 1ns / 1ps
package sdtp_pkg;

  localparam int MAX_DOCS = 256;
  localparam int MAX_PAGE = 64;

  localparam int DOC_W   = 32;
  localparam int SCORE_W = 32;
  localparam int TF_W    = 16;
  localparam int PAGE_W  = 16;
  localparam int PSIZE_W = 7;
  localparam int TOTAL_W = 9;
  localparam int CMD_W   = 2;

  localparam int IDX_W   = $clog2(MAX_DOCS);
  localparam int CNT_W   = $clog2(MAX_DOCS + 1);
  localparam int PSZ_W   = $clog2(MAX_PAGE + 1);
  localparam int PAGE_AW = (MAX_PAGE > 1) ? $clog2(MAX_PAGE) : 1;
  localparam int START_W = PAGE_W + PSIZE_W;
  localparam int ENTRY_W = DOC_W + SCORE_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EMIT  = 2'd2;

  // Per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_MATCH,
    CELL_UPDATE,
    CELL_RANK_LOAD,
    CELL_RANK,
    CELL_OUT_LOAD,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [DOC_W-1:0]    key;
    logic [DOC_W-1:0]    new_doc;
    logic [TF_W-1:0]     tf;
    logic                found;
  } cell_ctl_t;

  // Entry traveling along the ring
  typedef struct packed {
    logic                v;
    logic [DOC_W-1:0]    doc;
    logic [SCORE_W-1:0]  score;
    logic [IDX_W-1:0]    rank;
  } circ_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_RANK_LOAD,
    S_RANK,
    S_OUT_LOAD,
    S_OUT,
    S_RD,
    S_SHOW
  } state_t;

  // Saturating score accumulate
  function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] s,
                                                 input logic [TF_W-1:0] tf);
    logic [SCORE_W:0] sum;
    sum = {1'b0, s} + (SCORE_W+1)'(tf);
    return sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
  endfunction

endpackage

// File: design/sdtp_cell.sv
// One table cell: holds a document entry, its match flag and its rank.
// Depends on sdtp_pkg.
`timescale 1ns / 1ps
module sdtp_cell (
  input  logic                        clk,
  input  logic [sdtp_pkg::IDX_W-1:0]  idx,
  input  logic [sdtp_pkg::CNT_W-1:0]  count,
  input  sdtp_pkg::cell_ctl_t         ctl,
  input  sdtp_pkg::circ_t             circ_in,
  output sdtp_pkg::circ_t             circ_out,
  output logic                        match
);
  import sdtp_pkg::*;

  logic [DOC_W-1:0]   doc;
  logic [SCORE_W-1:0] score;
  logic [IDX_W-1:0]   rank;
  circ_t              circ;
  logic               own_valid;
  logic               ahead;

  assign own_valid = CNT_W'(idx) < count;

  // Passing entry ranks ahead of ours: higher score, then lower id
  assign ahead = circ_in.v && ((circ_in.score > score) ||
                 ((circ_in.score == score) && (circ_in.doc < doc)));

  assign circ_out = circ;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_IDLE: ;
      CELL_MATCH: match <= own_valid && (doc == ctl.key);
      CELL_UPDATE: begin
        if (match) begin
          score <= sat_add(score, ctl.tf);
        end else if (!ctl.found && (count == CNT_W'(idx))) begin
          doc   <= ctl.new_doc;
          score <= SCORE_W'(ctl.tf);
        end
      end
      CELL_RANK_LOAD: begin
        circ <= '{v: own_valid, doc: doc, score: score, rank: '0};
        rank <= '0;
      end
      CELL_RANK: begin
        circ <= circ_in;
        if (ahead) begin
          rank <= rank + 1'b1;
        end
      end
      CELL_OUT_LOAD: circ <= '{v: own_valid, doc: doc, score: score, rank: rank};
      CELL_SHIFT: circ <= circ_in;
      default: ;
    endcase
  end

endmodule

// File: design/sdtp_page_buf.sv
// Page buffer: one result page, written by rank, read in page order.
// Depends on sdtp_pkg.
`timescale 1ns / 1ps
module sdtp_page_buf (
  input  logic                          clk,
  input  logic                          we,
  input  logic [sdtp_pkg::PAGE_AW-1:0]  waddr,
  input  logic [sdtp_pkg::ENTRY_W-1:0]  wdata,
  input  logic [sdtp_pkg::PAGE_AW-1:0]  raddr,
  output logic [sdtp_pkg::ENTRY_W-1:0]  rdata
);
  import sdtp_pkg::*;

  logic [ENTRY_W-1:0] mem [MAX_PAGE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/scored_doc_topk_pager.sv
// Scored document top-k pager: top level, control and the ring of cells.
// Depends on sdtp_pkg, sdtp_cell, sdtp_page_buf and the defines header.
//
// Input channel (in_valid / in_stall) carries one command per transfer:
// clear, add posting, or emit page. One command is worked on at a time;
// in_stall is high until the current command is finished.
// Add: all cells compare the id in the transfer cycle, the hit cell
// accumulates (or the next free cell is written) in the following cycle.
// Emit: an empty page gives its single result in the cycle after the
// transfer. Otherwise the ring of MAX_DOCS cells rotates once to rank
// every entry, rotates again to drop the page into the page buffer,
// then each result is read from the buffer and then presented.
// Output channel (out_valid / out_stall): results hold steady while
// out_stall is high; the block waits until each one is transferred.
// Reset (rst, synchronous) empties the table and clears the overflow flag;
// no clearing pass is needed.
`timescale 1ns / 1ps
`include "scored_doc_topk_pager_defines.svh"
module scored_doc_topk_pager (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sdtp_pkg::CMD_W-1:0]    cmd,
  input  logic [sdtp_pkg::DOC_W-1:0]    doc_id,
  input  logic [sdtp_pkg::TF_W-1:0]     term_freq,
  input  logic [sdtp_pkg::PAGE_W-1:0]   page_number,
  input  logic [sdtp_pkg::PSIZE_W-1:0]  page_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdtp_pkg::DOC_W-1:0]    out_doc_id,
  output logic [sdtp_pkg::SCORE_W-1:0]  out_score,
  output logic [sdtp_pkg::TOTAL_W-1:0]  total_docs,
  output logic                          item_valid,
  output logic                          last_item,
  output logic                          table_overflow
);
  import sdtp_pkg::*;

  state_t               state, state_next;
  logic [CNT_W-1:0]     count;
  logic                 overflow;
  logic [DOC_W-1:0]     doc_q;
  logic [TF_W-1:0]      tf_q;
  logic [START_W-1:0]   start_q;
  logic [START_W-1:0]   end_q;
  logic [PSZ_W-1:0]     len_q;
  logic                 empty_q;
  logic [IDX_W-1:0]     rot;
  logic [PSZ_W-1:0]     rd_idx;

  logic                 in_acc;
  logic                 out_acc;
  logic                 found;
  logic                 rot_done;
  logic                 last_c;
  cell_ctl_t            ctl;
  logic [MAX_DOCS-1:0]  match_vec;
  circ_t                circ [MAX_DOCS];
  circ_t                tap;

  logic [PSZ_W-1:0]     psize_sat;
  logic [START_W-1:0]   start_c;
  logic [START_W:0]     end_raw;
  logic [START_W-1:0]   end_c;
  logic                 empty_c;

  logic                 buf_we;
  logic [PAGE_AW-1:0]   buf_waddr;
  logic [START_W-1:0]   rank_off;
  logic [ENTRY_W-1:0]   buf_rdata;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign found    = |match_vec;
  assign rot_done = (rot == IDX_W'(MAX_DOCS - 1));
  assign tap      = circ[MAX_DOCS-1];

  // Page window from the emit command
  always_comb begin
    psize_sat = (page_size > PSIZE_W'(MAX_PAGE)) ? PSZ_W'(MAX_PAGE) : PSZ_W'(page_size);
    start_c   = START_W'(page_number) * START_W'(psize_sat);
    end_raw   = (START_W+1)'(start_c) + (START_W+1)'(psize_sat);
    end_c     = (end_raw > (START_W+1)'(count)) ? START_W'(count) : START_W'(end_raw);
    empty_c   = (psize_sat == '0) || (start_c >= START_W'(count));
  end

  // Ring of cells
  for (genvar g = 0; g < MAX_DOCS; g++) begin : g_cell
    sdtp_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(g)),
      .count    (count),
      .ctl      (ctl),
      .circ_in  (circ[(g + MAX_DOCS - 1) % MAX_DOCS]),
      .circ_out (circ[g]),
      .match    (match_vec[g])
    );
  end

  // Page buffer write: entries whose rank falls inside the page
  assign rank_off  = START_W'(tap.rank) - start_q;
  assign buf_waddr = rank_off[PAGE_AW-1:0];
  assign buf_we    = (state == S_OUT) && tap.v &&
                     (START_W'(tap.rank) >= start_q) && (START_W'(tap.rank) < end_q);

  sdtp_page_buf u_page_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata ({tap.doc, tap.score}),
    .raddr (rd_idx[PAGE_AW-1:0]),
    .rdata (buf_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_ADD:  state_next = S_UPDATE;
            CMD_EMIT: state_next = empty_c ? S_SHOW : S_RANK_LOAD;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_UPDATE:    state_next = S_IDLE;
      S_RANK_LOAD: state_next = S_RANK;
      S_RANK:      state_next = rot_done ? S_OUT_LOAD : S_RANK;
      S_OUT_LOAD:  state_next = S_OUT;
      S_OUT:       state_next = rot_done ? S_RD : S_OUT;
      S_RD:        state_next = S_SHOW;
      S_SHOW: begin
        if (out_acc) begin
          state_next = last_c ? S_IDLE : S_RD;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl.key     = doc_id;
    ctl.new_doc = doc_q;
    ctl.tf      = tf_q;
    ctl.found   = found;
    ctl.op      = CELL_IDLE;
    unique case (state)
      S_IDLE:      ctl.op = (in_acc && (cmd == CMD_ADD)) ? CELL_MATCH : CELL_IDLE;
      S_UPDATE:    ctl.op = CELL_UPDATE;
      S_RANK_LOAD: ctl.op = CELL_RANK_LOAD;
      S_RANK:      ctl.op = CELL_RANK;
      S_OUT_LOAD:  ctl.op = CELL_OUT_LOAD;
      S_OUT:       ctl.op = CELL_SHIFT;
      default:     ctl.op = CELL_IDLE;
    endcase
    in_stall  = (state != S_IDLE);
    out_valid = (state == S_SHOW);
  end

  // Result fields
  assign last_c         = empty_q || ((rd_idx + 1'b1) == len_q);
  assign out_doc_id     = empty_q ? '0 : buf_rdata[ENTRY_W-1 -: DOC_W];
  assign out_score      = empty_q ? '0 : buf_rdata[SCORE_W-1:0];
  assign total_docs     = TOTAL_W'(count);
  assign item_valid     = !empty_q;
  assign last_item      = last_c;
  assign table_overflow = overflow;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_acc && cmd == CMD_CLEAR) begin
        count    <= '0;
        overflow <= 1'b0;
      end
      if (state == S_UPDATE && !found) begin
        if (count < CNT_W'(MAX_DOCS)) begin
          count <= count + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
    end
  end

  // Command and walk registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      doc_q   <= doc_id;
      tf_q    <= term_freq;
      start_q <= start_c;
      end_q   <= end_c;
      len_q   <= PSZ_W'(end_c - start_c);
      empty_q <= empty_c;
      rd_idx  <= '0;
    end
    if (state == S_RANK_LOAD || state == S_OUT_LOAD) begin
      rot <= '0;
    end else if (state == S_RANK || state == S_OUT) begin
      rot <= rot + 1'b1;
    end
    if (state == S_SHOW && out_acc && !last_c) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  // Checks
  `SDTP_ASSERT_IMP(a_one_match, state == S_UPDATE, $onehot0(match_vec), "document held twice")
  `SDTP_ASSERT_IMP(a_count_max, 1'b1, count <= CNT_W'(MAX_DOCS), "table count beyond capacity")
  `SDTP_ASSERT_IMP(a_empty_last, out_valid && !item_valid, last_item, "empty result not last")
  `SDTP_ASSERT_NEXT(a_clear, in_acc && cmd == CMD_CLEAR, count == '0 && !overflow, "clear failed")

endmodule
